// ===== rtl/core/fpa_pkg.sv =====
// Package with the types, opcodes and helper functions of the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int PROD_W    = 2 * DATA_W;

    // Stage 0 input, stage 1 operand prep, NUM_W divider steps, one rounding
    // stage and one output stage.
    localparam int DIV_FIRST  = 2;
    localparam int DIV_LAST   = DIV_FIRST + NUM_W - 1;
    localparam int ROUND_STG  = DIV_LAST + 1;
    localparam int LAST_STG   = ROUND_STG + 1;
    localparam int STAGE_CNT  = LAST_STG + 1;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_GT     = 4'd4,
        OP_LT     = 4'd5,
        OP_GE     = 4'd6,
        OP_LE     = 4'd7,
        OP_EQ     = 4'd8,
        OP_NE     = 4'd9,
        OP_MIN    = 4'd10,
        OP_MAX    = 4'd11,
        OP_INC    = 4'd12,
        OP_DEC    = 4'd13,
        OP_TO_INT = 4'd14
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } alu_status_t;

    typedef struct packed {
        alu_op_t                   op;
        logic signed [DATA_W-1:0]  operand_a;
        logic signed [DATA_W-1:0]  operand_b;
    } alu_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  value;
        logic                      compare_true;
        alu_status_t               status;
    } alu_rsp_t;

    typedef struct packed {
        alu_op_t            op;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic               neg;
        logic               dz;
        logic [DATA_W-1:0]  den;
        logic [NUM_W-1:0]   num;
        logic [DATA_W-1:0]  rem;
        logic [NUM_W:0]     quo;
        logic [PROD_W-1:0]  prod;
        logic [DATA_W-1:0]  res;
        logic               cmp;
        alu_status_t        st;
    } alu_stage_t;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic               overflow;
    } sat_t;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        mag = x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic sat_t saturate(input logic neg, input logic [PROD_W-1:0] q);
        logic [PROD_W-1:0] lim_pos;
        logic [PROD_W-1:0] lim_neg;
        sat_t              s;
        lim_pos = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lim_neg = lim_pos + 1'b1;
        s.overflow = 1'b0;
        if (!neg) begin
            if (q > lim_pos) begin
                s.overflow = 1'b1;
                s.value    = lim_pos[DATA_W-1:0];
            end
            else begin
                s.value = q[DATA_W-1:0];
            end
        end
        else begin
            if (q > lim_neg) begin
                s.overflow = 1'b1;
                s.value    = lim_neg[DATA_W-1:0];
            end
            else begin
                s.value = ~q[DATA_W-1:0] + 1'b1;
            end
        end
        saturate = s;
    endfunction

endpackage

// ===== rtl/core/fixed_point_alu_core.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
//  Channel | Signals                    | Payload
//  --------+----------------------------+-----------------------------
//  request | req_valid / req_ready      | req: op, operand_a, operand_b
//  result  | rsp_valid / rsp_ready      | rsp: value, compare_true, status
//
// Every operation takes the same path of NUM_W + 4 stages; the restoring
// divider, one quotient bit per stage, sets the depth. One beat enters per
// cycle unless a stalled result backs up the pipeline. Reset clears only the
// valid bits. A stalled result holds the output stage, and each stage still
// takes a new beat when it is empty, so bubbles are filled during a stall.
`timescale 1ns / 1ps
module fixed_point_alu_core
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  alu_req_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output alu_rsp_t  rsp
);

    alu_stage_t stage_reg [0:LAST_STG];
    logic       valid_reg [0:LAST_STG];
    logic       en        [0:LAST_STG];

    assign en[LAST_STG] = !valid_reg[LAST_STG] || rsp_ready;

    genvar i;
    generate
        for (i = 0; i < LAST_STG; i++) begin : g_en
            assign en[i] = !valid_reg[i] || en[i+1];
        end

        for (i = 0; i <= LAST_STG; i++) begin : g_stage
            alu_stage_t stage_next;
            logic       valid_next;

            if (i == 0) begin : g_in
                always_comb
                begin
                    stage_next    = '0;
                    stage_next.op = req.op;
                    stage_next.a  = req.operand_a;
                    stage_next.b  = req.operand_b;
                end
                assign valid_next = req_valid;
            end
            else if (i == 1) begin : g_prep
                alu_stage_t p;
                logic       a_lt_b;
                logic       b_lt_a;
                always_comb
                begin
                    p          = stage_reg[0];
                    a_lt_b     = $signed(p.a) < $signed(p.b);
                    b_lt_a     = $signed(p.b) < $signed(p.a);
                    stage_next = p;
                    stage_next.neg  = p.a[DATA_W-1] ^ p.b[DATA_W-1];
                    stage_next.dz   = (p.b == '0);
                    stage_next.den  = mag(p.b);
                    stage_next.num  = {mag(p.a), {FRAC_BITS{1'b0}}};
                    stage_next.rem  = '0;
                    stage_next.quo  = '0;
                    stage_next.prod = '0;
                    stage_next.res  = '0;
                    stage_next.cmp  = 1'b0;
                    stage_next.st   = ST_OK;
                    case (p.op)
                        OP_ADD:    stage_next.res = p.a + p.b;
                        OP_SUB:    stage_next.res = p.a - p.b;
                        OP_GT:     stage_next.cmp = b_lt_a;
                        OP_LT:     stage_next.cmp = a_lt_b;
                        OP_GE:     stage_next.cmp = !a_lt_b;
                        OP_LE:     stage_next.cmp = !b_lt_a;
                        OP_EQ:     stage_next.cmp = (p.a == p.b);
                        OP_NE:     stage_next.cmp = (p.a != p.b);
                        OP_MIN:    stage_next.res = a_lt_b ? p.a : p.b;
                        OP_MAX:    stage_next.res = b_lt_a ? p.a : p.b;
                        OP_INC:    stage_next.res = p.a + 1'b1;
                        OP_DEC:    stage_next.res = p.a - 1'b1;
                        OP_TO_INT: stage_next.res = $signed(p.a) >>> FRAC_BITS;
                        default:   stage_next.res = '0;
                    endcase
                end
                assign valid_next = valid_reg[0];
            end
            else if (i <= DIV_LAST) begin : g_div
                alu_stage_t        p;
                logic [DATA_W:0]   rem_sh;
                logic              q_bit;
                always_comb
                begin
                    p          = stage_reg[i-1];
                    stage_next = p;
                    rem_sh     = {p.rem, p.num[NUM_W-1]};
                    q_bit      = (rem_sh >= {1'b0, p.den});
                    stage_next.rem = q_bit ? DATA_W'(rem_sh - {1'b0, p.den})
                                           : rem_sh[DATA_W-1:0];
                    stage_next.num = {p.num[NUM_W-2:0], 1'b0};
                    stage_next.quo = {p.quo[NUM_W-1:0], q_bit};
                    // The multiply rides along: product first, rounding next.
                    if (i == DIV_FIRST) begin
                        stage_next.prod = PROD_W'(p.a[DATA_W-1] ? mag(p.a) : p.a)
                                        * PROD_W'(p.den);
                    end
                    if (i == DIV_FIRST + 1) begin
                        stage_next.prod = (p.prod + (PROD_W'(1) << (FRAC_BITS - 1)))
                                          >> FRAC_BITS;
                    end
                end
                assign valid_next = valid_reg[i-1];
            end
            else if (i == ROUND_STG) begin : g_round
                alu_stage_t p;
                always_comb
                begin
                    p          = stage_reg[i-1];
                    stage_next = p;
                    // Round half up on the magnitude: twice the remainder
                    // against the divisor.
                    if ({p.rem, 1'b0} >= {1'b0, p.den}) begin
                        stage_next.quo = p.quo + 1'b1;
                    end
                end
                assign valid_next = valid_reg[i-1];
            end
            else begin : g_out
                alu_stage_t p;
                sat_t       s_mul;
                sat_t       s_div;
                always_comb
                begin
                    p          = stage_reg[i-1];
                    stage_next = p;
                    s_mul      = saturate(p.neg, p.prod);
                    s_div      = saturate(p.neg, PROD_W'(p.quo));
                    case (p.op)
                        OP_MUL:
                        begin
                            stage_next.res = s_mul.value;
                            stage_next.st  = s_mul.overflow ? ST_OVERFLOW : ST_OK;
                        end
                        OP_DIV:
                        begin
                            if (p.dz) begin
                                stage_next.res = '0;
                                stage_next.st  = ST_DIV_ZERO;
                            end
                            else begin
                                stage_next.res = s_div.value;
                                stage_next.st  = s_div.overflow ? ST_OVERFLOW : ST_OK;
                            end
                        end
                        default:
                        begin
                            stage_next.res = p.res;
                        end
                    endcase
                end
                assign valid_next = valid_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en[i]) begin
                    valid_reg[i] <= valid_next;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i]) begin
                    stage_reg[i] <= stage_next;
                end
            end
        end
    endgenerate

    assign req_ready = en[0];
    assign rsp_valid = valid_reg[LAST_STG];

    always_comb
    begin
        rsp.value        = stage_reg[LAST_STG].res;
        rsp.compare_true = stage_reg[LAST_STG].cmp;
        rsp.status       = stage_reg[LAST_STG].st;
    end

endmodule

// ===== rtl/core/fpa_checker.sv =====
// Port checker for the fixed-point ALU and its bind to the top level.
`timescale 1ns / 1ps
module fpa_checker
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  alu_req_t  req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  alu_rsp_t  rsp
);

    // No result beat is offered while reset is held.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    // A comparison outcome comes with a zero value and a clean status.
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.compare_true) |-> (rsp.value == '0 && rsp.status == ST_OK))
        else $error("comparison beat carries value or status");

    // A division by zero always reports a zero value.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_DIV_ZERO) |-> (rsp.value == '0 && !rsp.compare_true))
        else $error("division by zero with nonzero value");

    // An overflow saturates to one of the two range limits.
    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_OVERFLOW)
            |-> (rsp.value == 32'sh7FFFFFFF || rsp.value == 32'sh80000000))
        else $error("overflow value is not a range limit");

    // A stalled result beat stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result beat changed");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== dv/tb_fixed_point_alu_core.sv =====
// Self-checking testbench for the pipelined fixed-point ALU core.
`timescale 1ns / 1ps
module tb_fixed_point_alu_core;
    import fpa_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    alu_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    alu_rsp_t rsp;

    alu_rsp_t expected_rsps[$];
    int       error_count;
    int       cycle_count;
    bit       stalls_on;

    localparam int CYCLE_LIMIT = 400000;

    fixed_point_alu_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] magnitude_of(input logic [31:0] x);
        magnitude_of = x[31] ? {32'd0, (~x + 32'd1)} : {32'd0, x};
    endfunction

    function automatic alu_rsp_t clamp_result(input logic neg, input logic [63:0] q);
        alu_rsp_t r;
        r = '0;
        r.status = ST_OK;
        if (!neg)
        begin
            if (q > 64'h7FFF_FFFF)
            begin
                r.value  = 32'h7FFF_FFFF;
                r.status = ST_OVERFLOW;
            end
            else
                r.value = q[31:0];
        end
        else
        begin
            if (q > 64'h8000_0000)
            begin
                r.value  = 32'h8000_0000;
                r.status = ST_OVERFLOW;
            end
            else
                r.value = -q[31:0];
        end
        return r;
    endfunction

    function automatic alu_rsp_t compute_alu(input alu_req_t rq);
        alu_rsp_t          r;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        q;
        a = rq.operand_a;
        b = rq.operand_b;
        r = '0;
        r.status = ST_OK;
        case (rq.op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL:
            begin
                q = (magnitude_of(a) * magnitude_of(b) + (64'd1 << (FRAC_BITS - 1)))
                    >> FRAC_BITS;
                r = clamp_result(a[31] ^ b[31], q);
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.status = ST_DIV_ZERO;
                else
                begin
                    num = magnitude_of(a) << FRAC_BITS;
                    den = magnitude_of(b);
                    q   = (2 * num + den) / (2 * den);
                    r   = clamp_result(a[31] ^ b[31], q);
                end
            end
            OP_GT: r.compare_true = a > b;
            OP_LT: r.compare_true = a < b;
            OP_GE: r.compare_true = a >= b;
            OP_LE: r.compare_true = a <= b;
            OP_EQ: r.compare_true = a == b;
            OP_NE: r.compare_true = a != b;
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (b < a) ? a : b;
            OP_INC: r.value = a + 1;
            OP_DEC: r.value = a - 1;
            OP_TO_INT: r.value = a >>> FRAC_BITS;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // leaving valid high so that the next beat can follow with no gap.
    task automatic send_request(input alu_op_t op, input logic [31:0] a,
                                input logic [31:0] b);
        while (stalls_on && $urandom_range(99) < 26)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid     <= 1'b1;
        req.op        <= op;
        req.operand_a <= a;
        req.operand_b <= b;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsps.push_back(compute_alu('{op, a, b}));
        @(negedge clk);
    endtask

    // Operand with a bias toward edge values and small magnitudes.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: pick_operand = 32'h7FFF_FFFF - $urandom_range(2);
            1: pick_operand = 32'h8000_0000 + $urandom_range(2);
            2: pick_operand = $urandom_range(2) - 1;
            3, 4: pick_operand = $urandom_range(131072) - 65536;
            5: pick_operand = {{16{1'b0}}, 16'($urandom)} * (($urandom_range(1)) ? 1 : -1);
            default: pick_operand = $urandom;
        endcase
    endfunction

    task automatic test_edge_operands();
        logic [31:0] vals[6];
        vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100};
        for (int i = 0; i < 6; i++)
            send_request(alu_op_t'(i % 15), vals[i], vals[5 - i]);
    endtask

    task automatic test_every_op();
        for (int op = 0; op <= OP_TO_INT; op++)
            send_request(alu_op_t'(op), 32'hFFFF_FE80, 32'h0000_0280);
    endtask

    task automatic test_special_cases();
        send_request(OP_DIV, 32'h0000_1234, 32'h0);
        send_request(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(OP_MUL, 32'h8000_0000, 32'h0000_0100);
        send_request(OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_MUL, 32'h0000_0080, 32'hFFFF_FF80);
        send_request(OP_MIN, 32'h0000_0500, 32'h0000_0500);
        send_request(OP_TO_INT, 32'hFFFF_FF01, 32'h0);
    endtask

    task automatic test_random_ops(input int count);
        for (int i = 0; i < count; i++)
        begin
            // A stretch of 200 requests after the first third goes without idling on either side.
            stalls_on = !(i >= count / 3 && i < count / 3 + 200);
            send_request(alu_op_t'($urandom_range(14)), pick_operand(), pick_operand());
        end
        stalls_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        alu_rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result beat value=%h", rsp.value);
                error_count++;
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (rsp.value !== exp_rsp.value)
                begin
                    $error("value: expected %h actual %h", exp_rsp.value, rsp.value);
                    error_count++;
                end
                if (rsp.compare_true !== exp_rsp.compare_true)
                begin
                    $error("compare_true: expected %b actual %b",
                           exp_rsp.compare_true, rsp.compare_true);
                    error_count++;
                end
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d actual %0d", exp_rsp.status, rsp.status);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
        rsp_ready <= !stalls_on || ($urandom_range(99) >= 26);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        stalls_on     = 1'b1;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_ready     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_operands();
        test_every_op();
        test_special_cases();
        test_random_ops(1300);
        req_valid <= 1'b0;

        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (STAGE_CNT + 10) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== fixed_point_alu_core.f =====
rtl/core/fpa_pkg.sv
rtl/core/fixed_point_alu_core.sv
rtl/core/fpa_checker.sv
dv/tb_fixed_point_alu_core.sv
